@@ rtl/core/tga_rle_pixel_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the TGA run-length pixel decoder
// Concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// A condition that holds at every clock edge.
`define TGA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// A condition in one cycle that implies another in the next cycle.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGA_ASSERT_ALWAYS(label, expr, msg)
`define TGA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Shared constants, register indexes, structs and clamping functions.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Image size limits.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Width of the size registers and of the position counters.
  localparam int DIM_W = 13;
  localparam int POS_W = 12;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_BPP      = 3'd0;
  localparam logic [2:0] REG_RLE      = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_TOP_DOWN = 3'd4;
  localparam logic [2:0] REG_REVERSED = 3'd5;

  // Placement settings handed to the segment unit.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [POS_W-1:0] first_col;
    logic [POS_W-1:0] last_row;
    logic             rows_top_down;
    logic             columns_reversed;
  } place_cfg_t;

  // One segment of a run as worked out by the segment unit.
  typedef struct packed {
    logic [7:0]       seg;
    logic             row_end;
    logic             done;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;
  } seg_result_t;

  // Bytes per pixel, clamped to 1..4.
  function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
    logic [2:0] r;
    if (bpp == 3'd0) r = 3'd1;
    else if (bpp > 3'd4) r = 3'd4;
    else r = bpp;
    return r;
  endfunction

  // Row width, clamped to 4..MAX_WIDTH.
  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] r;
    if (w < DIM_W'(4)) r = DIM_W'(4);
    else if (w > DIM_W'(MAX_WIDTH)) r = DIM_W'(MAX_WIDTH);
    else r = w;
    return r;
  endfunction

  // Row count, clamped to 1..MAX_HEIGHT.
  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] r;
    if (h == '0) r = DIM_W'(1);
    else if (h > DIM_W'(MAX_HEIGHT)) r = DIM_W'(MAX_HEIGHT);
    else r = h;
    return r;
  endfunction

endpackage

@@ rtl/core/tgarle_seg_unit.sv @@
// ----------------------------------------------------------------------------
// TGA run segment unit
// Cuts the next segment off a pending run at the current position: room left
// in the row, segment length, row end and image end, and the next position.
// ----------------------------------------------------------------------------
module tgarle_seg_unit (
  input  tgarle_pkg::place_cfg_t           cfg,
  input  logic [7:0]                       count,
  input  logic [tgarle_pkg::POS_W-1:0]     col,
  input  logic [tgarle_pkg::POS_W-1:0]     row,
  output tgarle_pkg::seg_result_t          res
);
  import tgarle_pkg::*;

  logic [DIM_W-1:0] room;

  // Pixels left in the row in the fill direction.
  always_comb begin
    if (cfg.columns_reversed) begin
      room = {1'b0, col} + DIM_W'(1);
    end else begin
      room = cfg.width - {1'b0, col};
    end
  end

  // Segment length, end conditions and the position that follows.
  always_comb begin
    res.row_end = {{(DIM_W-8){1'b0}}, count} >= room;
    res.seg     = res.row_end ? room[7:0] : count;
    res.done    = res.row_end && (row == cfg.last_row);
    if (res.row_end) begin
      res.col_next = cfg.first_col;
    end else if (cfg.columns_reversed) begin
      res.col_next = col - {{(POS_W-8){1'b0}}, res.seg};
    end else begin
      res.col_next = col + {{(POS_W-8){1'b0}}, res.seg};
    end
    if (res.row_end && !res.done) begin
      res.row_next = cfg.rows_top_down ? row + POS_W'(1) : row - POS_W'(1);
    end else begin
      res.row_next = row;
    end
  end

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: one byte per cycle while pixels are gathered.
// A completed pixel holds the input until all its row segments are placed
// (1 to 33 of them), as the single segment unit cuts one row segment a cycle
// unless the output stalls; the first run is registered once the last byte
// has put the sequencer in placement. Synchronous reset, or a write to a
// defined register, restarts the image; input is held while positions reload.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  // Run output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_word,
  output logic [11:0] start_x,
  output logic [11:0] row_y,
  output logic [7:0]  run_length,
  output logic        image_complete,
  output logic        last_of_burst
);
  import tgarle_pkg::*;
  `include "tga_rle_pixel_decoder_defines.svh"

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PLACE = 1'b1;

  // Configuration registers
  logic [2:0]       bytes_per_pixel;
  logic             rle_mode;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             rows_top_down;
  logic             columns_reversed;
  logic             restart_req;

  // Decoder state
  logic             state;
  logic             awaiting_header;
  logic             packet_is_repeat;
  logic [7:0]       pixels_left;
  logic [1:0]       byte_index;
  logic [31:0]      pixel_gather;
  logic [POS_W-1:0] column_position;
  logic [POS_W-1:0] row_position;
  logic             image_finished;
  logic [31:0]      run_word;
  logic [7:0]       run_count;

  logic [2:0]       reg_index;
  logic             cfg_write;
  logic [DIM_W-1:0] width_e;
  logic [DIM_W-1:0] height_m1;
  place_cfg_t       place_cfg;
  seg_result_t      seg;
  logic             in_fire;
  logic             step_fire;
  logic [31:0]      gather_new;
  logic             pixel_done;
  logic [7:0]       left_dec;
  logic [7:0]       count_after;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    case (reg_index)
      REG_BPP:      prdata = {29'd0, bytes_per_pixel};
      REG_RLE:      prdata = {31'd0, rle_mode};
      REG_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, image_width};
      REG_HEIGHT:   prdata = {{(32-DIM_W){1'b0}}, image_height};
      REG_TOP_DOWN: prdata = {31'd0, rows_top_down};
      REG_REVERSED: prdata = {31'd0, columns_reversed};
      default:      prdata = 32'd0;
    endcase
  end

  // Register writes; a write to a defined register asks for a restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel  <= 3'd3;
      rle_mode         <= 1'b1;
      image_width      <= DIM_W'(640);
      image_height     <= DIM_W'(480);
      rows_top_down    <= 1'b0;
      columns_reversed <= 1'b0;
      restart_req      <= 1'b1;
    end else begin
      restart_req <= 1'b0;
      if (cfg_write) begin
        case (reg_index)
          REG_BPP: begin
            bytes_per_pixel <= pwdata[2:0];
            restart_req     <= 1'b1;
          end
          REG_RLE: begin
            rle_mode    <= pwdata[0];
            restart_req <= 1'b1;
          end
          REG_WIDTH: begin
            image_width <= pwdata[DIM_W-1:0];
            restart_req <= 1'b1;
          end
          REG_HEIGHT: begin
            image_height <= pwdata[DIM_W-1:0];
            restart_req  <= 1'b1;
          end
          REG_TOP_DOWN: begin
            rows_top_down <= pwdata[0];
            restart_req   <= 1'b1;
          end
          REG_REVERSED: begin
            columns_reversed <= pwdata[0];
            restart_req      <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Effective placement settings.
  assign width_e   = eff_width(image_width);
  assign height_m1 = eff_height(image_height) - DIM_W'(1);

  always_comb begin
    place_cfg.width            = width_e;
    place_cfg.first_col        = columns_reversed ? POS_W'(width_e - DIM_W'(1)) : '0;
    place_cfg.last_row         = rows_top_down ? height_m1[POS_W-1:0] : '0;
    place_cfg.rows_top_down    = rows_top_down;
    place_cfg.columns_reversed = columns_reversed;
  end

  tgarle_seg_unit u_seg (
    .cfg   (place_cfg),
    .count (run_count),
    .col   (column_position),
    .row   (row_position),
    .res   (seg)
  );

  // Handshakes and byte gathering.
  assign in_ready    = (state == ST_IDLE) && !restart_req;
  assign in_fire     = in_valid && in_ready;
  assign step_fire   = (state == ST_PLACE) && (!out_valid || out_ready);
  assign gather_new  = pixel_gather | ({24'd0, stream_byte} << {byte_index, 3'b000});
  assign pixel_done  = ({1'b0, byte_index} + 3'd1) >= eff_bpp(bytes_per_pixel);
  assign left_dec    = (pixels_left != 8'd0) ? pixels_left - 8'd1 : 8'd0;
  assign count_after = run_count - seg.seg;

  // Packet parsing, pixel assembly and run placement.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      awaiting_header  <= 1'b1;
      packet_is_repeat <= 1'b0;
      pixels_left      <= 8'd0;
      byte_index       <= 2'd0;
      pixel_gather     <= 32'd0;
      column_position  <= '0;
      row_position     <= '0;
      image_finished   <= 1'b0;
      run_count        <= 8'd0;
    end else if (restart_req) begin
      state            <= ST_IDLE;
      awaiting_header  <= 1'b1;
      packet_is_repeat <= 1'b0;
      pixels_left      <= 8'd0;
      byte_index       <= 2'd0;
      pixel_gather     <= 32'd0;
      column_position  <= place_cfg.first_col;
      row_position     <= rows_top_down ? '0 : height_m1[POS_W-1:0];
      image_finished   <= 1'b0;
      run_count        <= 8'd0;
    end else if (in_fire && !image_finished) begin
      if (rle_mode && awaiting_header) begin
        packet_is_repeat <= stream_byte[7];
        pixels_left      <= {1'b0, stream_byte[6:0]} + 8'd1;
        awaiting_header  <= 1'b0;
        byte_index       <= 2'd0;
        pixel_gather     <= 32'd0;
      end else if (pixel_done) begin
        byte_index   <= 2'd0;
        pixel_gather <= 32'd0;
        run_word     <= gather_new;
        state        <= ST_PLACE;
        if (!rle_mode) begin
          run_count <= 8'd1;
        end else if (packet_is_repeat) begin
          run_count       <= pixels_left;
          pixels_left     <= 8'd0;
          awaiting_header <= 1'b1;
        end else begin
          run_count   <= 8'd1;
          pixels_left <= left_dec;
          if (left_dec == 8'd0) begin
            awaiting_header <= 1'b1;
          end
        end
      end else begin
        byte_index   <= byte_index + 2'd1;
        pixel_gather <= gather_new;
      end
    end else if (step_fire) begin
      run_count       <= count_after;
      column_position <= seg.col_next;
      row_position    <= seg.row_next;
      if (seg.done) begin
        image_finished <= 1'b1;
      end
      if (seg.done || (count_after == 8'd0)) begin
        state <= ST_IDLE;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pixel_word     <= run_word;
      start_x        <= column_position;
      row_y          <= row_position;
      run_length     <= seg.seg;
      image_complete <= seg.done;
      last_of_burst  <= seg.done || (count_after == 8'd0);
    end
  end

  // Checks on the sequencer and the position counters.
  `TGA_ASSERT_ALWAYS(a_count_nonzero, (state != ST_PLACE) || (run_count != 8'd0), "empty run")
  `TGA_ASSERT_ALWAYS(a_finished_idle, !image_finished || (state == ST_IDLE), "placing after end")
  `TGA_ASSERT_ALWAYS(a_col_in_row, restart_req || ({1'b0, column_position} < width_e), "col range")
  `TGA_ASSERT_NEXT(a_done_marks, step_fire && seg.done, image_finished && out_valid, "end lost")
  `TGA_ASSERT_NEXT(a_last_frees, step_fire && (count_after == 8'd0), in_ready || restart_req,
                   "input held after last segment")

endmodule

@@ tb/tga_rle_pixel_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// Run checker for the TGA run-length pixel decoder
// Watches the register port and both item channels, keeps its own model of
// packet parsing, pixel assembly and raster placement, and compares every
// run leaving the decoder with the oldest predicted run.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] pixel_word,
  input  logic [11:0] start_x,
  input  logic [11:0] row_y,
  input  logic [7:0]  run_length,
  input  logic        image_complete,
  input  logic        last_of_burst,
  output int          failures,
  output int          runs_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tgarle_pkg::*;

  // A single pixel can be cut into at most this many row segments.
  localparam int MAX_SEGMENTS = 33;

  typedef struct packed {
    logic [31:0] word;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  len;
    logic        complete;
    logic        last;
  } pixel_run_t;

  pixel_run_t expected_runs[$];

  // Register copies.
  logic [2:0]       bpp_reg;
  logic             rle_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             top_down_reg;
  logic             reversed_reg;

  // Decoder state as predicted.
  logic        want_header;
  logic        repeat_packet;
  int          pixels_left;
  int          byte_count;
  logic [31:0] gathered;
  int          col_pos;
  int          row_pos;
  logic        finished;

  int mismatches = 0;

  assign failures = mismatches;

  // Effective settings after clamping of out-of-range register values.
  function automatic int used_bpp();
    if (bpp_reg == 3'd0) return 1;
    if (bpp_reg > 3'd4) return 4;
    return int'(bpp_reg);
  endfunction

  function automatic int used_width();
    if (width_reg < 4) return 4;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int used_height();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic int final_row();
    return top_down_reg ? used_height() - 1 : 0;
  endfunction

  // Back to the start of an image with the current settings.
  task automatic restart_image();
    want_header   = 1'b1;
    repeat_packet = 1'b0;
    pixels_left   = 0;
    byte_count    = 0;
    gathered      = '0;
    col_pos       = reversed_reg ? used_width() - 1 : 0;
    row_pos       = top_down_reg ? 0 : used_height() - 1;
    finished      = 1'b0;
  endtask

  task automatic load_defaults();
    bpp_reg      = 3'd3;
    rle_reg      = 1'b1;
    width_reg    = DIM_W'(640);
    height_reg   = DIM_W'(480);
    top_down_reg = 1'b0;
    reversed_reg = 1'b0;
    restart_image();
  endtask

  // Any write to a known register restarts the image; other indexes do nothing.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_BPP:      bpp_reg = data[2:0];
      REG_RLE:      rle_reg = data[0];
      REG_WIDTH:    width_reg = data[DIM_W-1:0];
      REG_HEIGHT:   height_reg = data[DIM_W-1:0];
      REG_TOP_DOWN: top_down_reg = data[0];
      REG_REVERSED: reversed_reg = data[0];
      default: return;
    endcase
    restart_image();
  endtask

  // Lay count copies of word into the raster, one run per row segment.
  task automatic place_pixels(input logic [31:0] word, input int count);
    int         k;
    int         room;
    int         seg;
    logic       row_end;
    logic       fin;
    pixel_run_t r;
    k = 0;
    while (count > 0 && !finished && k < MAX_SEGMENTS) begin
      room       = reversed_reg ? col_pos + 1 : used_width() - col_pos;
      seg        = (count < room) ? count : room;
      row_end    = (seg == room);
      fin        = row_end && (row_pos == final_row());
      r.word     = word;
      r.x        = 12'(col_pos);
      r.y        = 12'(row_pos);
      r.len      = 8'(seg);
      r.complete = fin;
      count     -= seg;
      k++;
      r.last     = (count == 0) || fin || (k == MAX_SEGMENTS);
      expected_runs = {expected_runs, r};
      if (row_end) begin
        col_pos = reversed_reg ? used_width() - 1 : 0;
        if (fin) finished = 1'b1;
        else if (top_down_reg) row_pos++;
        else row_pos--;
      end else if (reversed_reg) begin
        col_pos -= seg;
      end else begin
        col_pos += seg;
      end
    end
  endtask

  // One accepted byte: packet header, part of a pixel, or ignored past the end.
  task automatic take_byte(input logic [7:0] b);
    logic [31:0] word;
    int          n;
    if (finished) return;
    if (rle_reg && want_header) begin
      repeat_packet = b[7];
      pixels_left   = int'(b[6:0]) + 1;
      want_header   = 1'b0;
      byte_count    = 0;
      gathered      = '0;
      return;
    end
    gathered |= 32'(b) << (8 * byte_count);
    byte_count++;
    if (byte_count < used_bpp()) return;
    word       = gathered;
    byte_count = 0;
    gathered   = '0;
    if (!rle_reg) begin
      place_pixels(word, 1);
    end else if (repeat_packet) begin
      n           = pixels_left;
      pixels_left = 0;
      want_header = 1'b1;
      place_pixels(word, n);
    end else begin
      if (pixels_left > 0) pixels_left--;
      if (pixels_left == 0) want_header = 1'b1;
      place_pixels(word, 1);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Runs leaving the decoder are checked before this edge's inputs are modelled.
  always @(posedge clk) begin
    pixel_run_t want;
    if (rst) begin
      load_defaults();
      expected_runs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("run with no item waiting: word 0x%0h x %0d y %0d length %0d",
                 pixel_word, start_x, row_y, run_length);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          compare_field("pixel_word", want.word, pixel_word);
          compare_field("start_x", 32'(want.x), 32'(start_x));
          compare_field("row_y", 32'(want.y), 32'(row_y));
          compare_field("run_length", 32'(want.len), 32'(run_length));
          compare_field("image_complete", 32'(want.complete), 32'(image_complete));
          compare_field("last_of_burst", 32'(want.last), 32'(last_of_burst));
        end
      end
      if (psel && penable && pwrite && pready) write_register(paddr[4:2], pwdata);
      if (in_valid && in_ready) take_byte(stream_byte);
    end
    runs_pending <= expected_runs.size();
  end

endmodule

@@ tb/tga_rle_pixel_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the TGA run-length pixel decoder
// Drives register settings and byte streams, paces the run output, and leaves
// prediction and comparison to the run checker beside the decoder.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgarle_pkg::*;

  localparam int         CLK_HALF      = 5;
  localparam int         RESET_CYCLES  = 8;
  localparam int         RANDOM_ITEMS  = 135;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         NUM_REGS      = 6;
  localparam logic [2:0] SPARE_REG_LO  = 3'd6;
  localparam logic [2:0] SPARE_REG_HI  = 3'd7;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_valid    = 1'b0;
  logic [7:0]  stream_byte = '0;
  logic        out_ready   = 1'b0;

  logic [31:0] prdata;
  logic        pready;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] pixel_word;
  logic [11:0] start_x;
  logic [11:0] row_y;
  logic [7:0]  run_length;
  logic        image_complete;
  logic        last_of_burst;

  int   failures;
  int   runs_pending;

  // Sender pacing and item bookkeeping.
  bit         in_calm      = 1'b0;
  int         random_items = 0;
  int         phase_sent   = 0;
  logic [7:0] script[$];

  // Long receiver hold-offs are requested by the stimulus and served by the pacer.
  int hold_requests = 0;
  int holds_served  = 0;
  bit hold_active   = 1'b0;

  tga_rle_pixel_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_word     (pixel_word),
    .start_x        (start_x),
    .row_y          (row_y),
    .run_length     (run_length),
    .image_complete (image_complete),
    .last_of_burst  (last_of_burst)
  );

  tga_rle_pixel_decoder_checker run_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_word     (pixel_word),
    .start_x        (start_x),
    .row_y          (row_y),
    .run_length     (run_length),
    .image_complete (image_complete),
    .last_of_burst  (last_of_burst),
    .failures       (failures),
    .runs_pending   (runs_pending)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Gap length: mostly none, sometimes short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Register write: waits for a clock edge, then a setup phase and an access phase held until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes every register in a rotated order from a random first one, sometimes with junk above its width.
  task automatic configure(input int bpp, input int rle, input int width,
                           input int height, input int top_down, input int reversed);
    logic [31:0] vals[NUM_REGS];
    logic [31:0] masks[NUM_REGS];
    logic [31:0] junk;
    int          first;
    int          idx;
    vals[REG_BPP]       = bpp;
    vals[REG_RLE]       = rle;
    vals[REG_WIDTH]     = width;
    vals[REG_HEIGHT]    = height;
    vals[REG_TOP_DOWN]  = top_down;
    vals[REG_REVERSED]  = reversed;
    masks[REG_BPP]      = 32'h7;
    masks[REG_RLE]      = 32'h1;
    masks[REG_WIDTH]    = (32'd1 << DIM_W) - 1;
    masks[REG_HEIGHT]   = (32'd1 << DIM_W) - 1;
    masks[REG_TOP_DOWN] = 32'h1;
    masks[REG_REVERSED] = 32'h1;
    first = $urandom_range(0, NUM_REGS - 1);
    for (int k = 0; k < NUM_REGS; k++) begin
      idx  = (first + k) % NUM_REGS;
      junk = ($urandom_range(0, 3) == 0) ? ($urandom & ~masks[idx]) : '0;
      write_reg(3'(idx), (vals[idx] & masks[idx]) | junk);
    end
  endtask

  // Offer one byte, keeping valid high when no gap is inserted before this byte.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random-phase byte, counted towards the item total.
  task automatic offer(input logic [7:0] b);
    random_items++;
    phase_sent++;
    send_byte(b);
  endtask

  task automatic play_script();
    foreach (script[i]) send_byte(script[i]);
  endtask

  // Pause the sender until every predicted run has come out, then let it settle.
  task automatic wait_for_runs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver pacing: random stalls, calm stretches, and requested long holds.
  initial begin : sink_pacing
    int stall;
    int calm_left;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        out_ready   <= 1'b0;
        hold_active  = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready   <= 1'b1;
        hold_active  = 1'b0;
        holds_served++;
      end else begin
        if (calm_left > 0) begin
          calm_left--;
          stall = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(30, 80);
          stall     = 0;
        end else begin
          stall = pick_gap();
        end
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Hang guard.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int         c_bpp;
    int         c_rle;
    int         c_width;
    int         c_height;
    int         r;
    int         bpp_eff;
    int         rle_on;
    int         budget;
    int         count;
    int         n;
    logic [7:0] header;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one long repeat packet, then a raw packet.
    script = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h01, 8'h02, 8'h03};
    play_script();
    wait_for_runs();

    // Tiny image, reversed columns, top-down: a repeat clipped at the image end,
    // then bytes past the end that must be ignored.
    configure(4, 1, 4, 2, 1, 1);
    script = '{8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h12, 8'h80};
    play_script();
    wait_for_runs();

    // Direct mode, one byte per pixel, a single row.
    configure(1, 0, 4, 1, 0, 0);
    script = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h3C};
    play_script();
    wait_for_runs();

    // Register values below range fall back to the smallest legal setting.
    configure(0, 1, 0, 0, 1, 0);
    script = '{8'h82, 8'h5A, 8'h00, 8'hA5};
    play_script();
    wait_for_runs();

    // Register values above range fall back to the largest legal setting.
    configure(7, 1, 8191, 8191, 0, 1);
    script = '{8'h80, 8'h11, 8'h22, 8'h33, 8'h44};
    play_script();
    wait_for_runs();

    // Receiver holds off while the sender keeps pushing long repeats into a
    // narrow image, so the decoder backs up and stalls its input.
    configure(1, 1, 4, 64, 0, 0);
    in_calm = 1'b1;
    hold_requests++;
    while (!hold_active) @(posedge clk);
    script = '{8'hFF, 8'h11, 8'hFF, 8'h22, 8'h83, 8'h33};
    play_script();
    wait_for_runs();

    // Random phases: new settings (or a write to an unused index), then mostly
    // well-formed packets with random content and some stray bytes.
    rle_on  = 1;
    bpp_eff = 1;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        write_reg(3'($urandom_range(SPARE_REG_LO, SPARE_REG_HI)), $urandom);
      end else begin
        c_bpp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        c_rle = ($urandom_range(0, 9) < 7) ? 1 : 0;
        r = $urandom_range(0, 19);
        if (r < 15) c_width = $urandom_range(4, 12);
        else if (r < 17) c_width = $urandom_range(0, 3);
        else if (r < 19) c_width = $urandom_range(13, 40);
        else c_width = $urandom_range(MAX_WIDTH, 8191);
        r = $urandom_range(0, 19);
        if (r < 14) c_height = $urandom_range(1, 4);
        else if (r < 16) c_height = 0;
        else if (r < 19) c_height = $urandom_range(5, 12);
        else c_height = $urandom_range(MAX_HEIGHT, 8191);
        configure(c_bpp, c_rle, c_width, c_height,
                  $urandom_range(0, 1), $urandom_range(0, 1));
        rle_on  = c_rle;
        bpp_eff = (c_bpp == 0) ? 1 : (c_bpp > 4) ? 4 : c_bpp;
      end
      in_calm    = ($urandom_range(0, 3) == 0);
      budget     = $urandom_range(8, 30);
      phase_sent = 0;
      while (phase_sent < budget) begin
        if (rle_on != 0 && $urandom_range(0, 6) != 0) begin
          r = $urandom_range(0, 9);
          if (r < 7) count = $urandom_range(0, 5);
          else if (r < 9) count = $urandom_range(6, 30);
          else count = $urandom_range(31, 127);
          header = {1'($urandom_range(0, 1)), 7'(count)};
          n = header[7] ? bpp_eff : (count + 1) * bpp_eff;
          offer(header);
          for (int i = 0; i < n && phase_sent < budget; i++) offer(8'($urandom));
        end else begin
          offer(8'($urandom));
        end
      end
      wait_for_runs();
    end

    if (failures == 0 && runs_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
